/* hw/rtl/edge_ratio_quality_macros.svh */
// Assertion macros for the edge ratio quality block.
// Included by the top level; depends on nothing else.
`ifndef EDGE_RATIO_QUALITY_MACROS_SVH
`define EDGE_RATIO_QUALITY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge_ratio_quality: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ERQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge_ratio_quality: assertion failed");

`endif

/* hw/rtl/erq_pkg.sv */
// Shared types and constants of the edge ratio quality block.
// Used by the sequencer, the compare-subtract unit and the top level.
`default_nettype none

package erq_pkg;

  // Field widths of the item formats.
  localparam int COORD_BITS        = 24;
  localparam int QUALITY_FRAC_BITS = 16;

  // Squared edge length: sum of three squares below 3 * 2^(2*COORD_BITS).
  localparam int SQ_W   = 2 * COORD_BITS + 2;
  // Divide quotient holds 2*Q fraction bits of min/max.
  localparam int QUO_W  = 2 * QUALITY_FRAC_BITS;
  // Shared compare-subtract width covers the divider and the root remainder.
  localparam int SUB_W  = (SQ_W + 1 > QUALITY_FRAC_BITS + 3) ?
                          (SQ_W + 1) : (QUALITY_FRAC_BITS + 3);
  // Step counter covers the longest phase, the divide.
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [STEP_W-1:0] SQ_LAST_STEP   = STEP_W'(2);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(QUO_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST_STEP = STEP_W'(QUALITY_FRAC_BITS - 1);

  localparam logic [QUALITY_FRAC_BITS-1:0] QUALITY_CAP = '1;

  // Axis codes for the squaring phase.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic                         last_edge;
  } erq_in_t;

  typedef struct packed {
    logic [QUALITY_FRAC_BITS-1:0] quality;
    logic                         degenerate;
  } erq_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_UPD,
    ST_DIV,
    ST_ROOT,
    ST_EMIT
  } erq_state_e;

  // Sequencer to datapath.
  typedef struct packed {
    erq_state_e        state;
    logic [STEP_W-1:0] step;
  } erq_ctrl_t;

  // Datapath to sequencer, valid in the update state.
  typedef struct packed {
    logic last;
    logic direct;
  } erq_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/erq_cmp_sub.sv */
// Shared compare-subtract unit used by the divider and the square root.
// Depends on erq_pkg for the operand width.
`default_nettype none

module erq_cmp_sub (
  input  wire logic [erq_pkg::SUB_W-1:0] a_i,
  input  wire logic [erq_pkg::SUB_W-1:0] b_i,
  output logic                           ge_o,
  output logic [erq_pkg::SUB_W-1:0]      diff_o
);
  import erq_pkg::*;

  logic [SUB_W:0] wide_diff;

  // One subtractor; the borrow out gives the compare.
  assign wide_diff = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o      = ~wide_diff[SUB_W];
  assign diff_o    = wide_diff[SUB_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/erq_seq.sv */
// Sequencer of the edge ratio quality block: phase state and step counter.
// Depends on erq_pkg for the state enum and the control structs.
`default_nettype none

module erq_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire erq_pkg::erq_stat_t stat_i,
  input  wire logic               out_free_i,
  output logic                    in_ready_o,
  output erq_pkg::erq_ctrl_t      ctrl_o
);
  import erq_pkg::*;

  erq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // State and step registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and outputs.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q + STEP_W'(1);
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        step_d     = '0;
        if (in_valid_i) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (step_q == SQ_LAST_STEP) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        step_d = '0;
        if (!stat_i.last) begin
          state_d = ST_IDLE;
        end else if (stat_i.direct) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == DIV_LAST_STEP) begin
          state_d = ST_ROOT;
          step_d  = '0;
        end
      end
      ST_ROOT: begin
        if (step_q == ROOT_LAST_STEP) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ctrl_o.state = state_q;
  assign ctrl_o.step  = step_q;

endmodule

`default_nettype wire

/* hw/rtl/edge_ratio_quality.sv */
// Top level of the edge ratio quality block: edge datapath and result register.
// Depends on erq_pkg, erq_seq, erq_cmp_sub and edge_ratio_quality_macros.svh.
//
//   Channel   Signals                              Item
//   input     in_valid_i / in_ready_o / in_item_i  one edge, two 3D endpoints
//   output    out_valid_o / out_ready_i / out_item_o  quality of one element
//
// An edge passes through accept, three squaring steps on one multiplier and update.
// A last edge adds 2*Q divide steps and Q root steps on the shared
// compare-subtract unit plus an emit state; a zero or equal min/max skips
// the divide and root. Reset clears the element state.
// A result waits in the output register while the next edge is accepted; the
// block stalls in its emit state only if that register is still full.
`default_nettype none
`include "edge_ratio_quality_macros.svh"

module edge_ratio_quality (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire erq_pkg::erq_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output erq_pkg::erq_out_t      out_item_o
);
  import erq_pkg::*;

  localparam int Q = QUALITY_FRAC_BITS;
  localparam int D = COORD_BITS + 1;

  erq_ctrl_t ctrl;
  erq_stat_t stat;
  logic      out_free;
  logic      in_accept;

  erq_in_t            in_q;
  logic [SQ_W-1:0]    acc_q, min_q, max_q;
  logic               in_elem_q;
  logic [SUB_W-1:0]   rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic [Q-1:0]       root_q;
  logic               deg_q;
  erq_out_t           out_q;
  logic               out_valid_q;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  erq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // Axis select and absolute coordinate difference.
  logic signed [COORD_BITS-1:0] sel_a, sel_b;
  logic signed [D-1:0]          diff;
  logic [D-1:0]                 abs_diff;
  logic [2*D-1:0]               sq;

  always_comb begin
    case (ctrl.step[1:0])
      AXIS_X: begin
        sel_a = in_q.ax;
        sel_b = in_q.bx;
      end
      AXIS_Y: begin
        sel_a = in_q.ay;
        sel_b = in_q.by;
      end
      AXIS_Z: begin
        sel_a = in_q.az;
        sel_b = in_q.bz;
      end
      default: begin
        sel_a = in_q.az;
        sel_b = in_q.bz;
      end
    endcase
  end

  assign diff     = D'(sel_a) - D'(sel_b);
  assign abs_diff = diff[D-1] ? D'(-diff) : D'(diff);
  assign sq       = abs_diff * abs_diff;

  // Running min and max including the current edge.
  logic [SQ_W-1:0] new_min, new_max;
  logic            max_zero, min_eq_max;

  assign new_min    = (!in_elem_q || acc_q < min_q) ? acc_q : min_q;
  assign new_max    = (!in_elem_q || acc_q > max_q) ? acc_q : max_q;
  assign max_zero   = (new_max == '0);
  assign min_eq_max = (new_min == new_max);
  assign stat.last   = in_q.last_edge;
  assign stat.direct = max_zero || min_eq_max;

  // Shared compare-subtract operands: divide step or root step.
  logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
  logic             sub_ge;

  always_comb begin
    case (ctrl.state)
      ST_DIV: begin
        sub_a = {rem_q[SUB_W-2:0], 1'b0};
        sub_b = SUB_W'(max_q);
      end
      default: begin
        sub_a = {rem_q[SUB_W-3:0], quo_q[QUO_W-1 -: 2]};
        sub_b = SUB_W'({root_q, 2'b01});
      end
    endcase
  end

  erq_cmp_sub u_cmp_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .ge_o   (sub_ge),
    .diff_o (sub_diff)
  );

  // Input capture and squared-length accumulation.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q  <= in_item_i;
      acc_q <= '0;
    end else if (ctrl.state == ST_SQ) begin
      acc_q <= acc_q + SQ_W'(sq);
    end
  end

  // Element state: running min, max and open-element flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '0;
      max_q     <= '0;
      in_elem_q <= 1'b0;
    end else if (ctrl.state == ST_UPD) begin
      min_q     <= new_min;
      max_q     <= new_max;
      in_elem_q <= !in_q.last_edge;
    end
  end

  // Divide min/max to 2*Q fraction bits, then take the integer root.
  always_ff @(posedge clk_i) begin
    case (ctrl.state)
      ST_UPD: begin
        rem_q  <= SUB_W'(new_min);
        quo_q  <= '0;
        deg_q  <= max_zero;
        root_q <= (!max_zero && min_eq_max) ? QUALITY_CAP : '0;
      end
      ST_DIV: begin
        quo_q <= {quo_q[QUO_W-2:0], sub_ge};
        if (ctrl.step == DIV_LAST_STEP) begin
          rem_q <= '0;
        end else begin
          rem_q <= sub_ge ? sub_diff : sub_a;
        end
      end
      ST_ROOT: begin
        rem_q  <= sub_ge ? sub_diff : sub_a;
        root_q <= {root_q[Q-2:0], sub_ge};
        quo_q  <= {quo_q[QUO_W-3:0], 2'b00};
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.state == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.state == ST_EMIT && out_free) begin
      out_q.quality    <= root_q;
      out_q.degenerate <= deg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks on the element state and the result path.
  `ERQ_ASSERT_NOW(a_min_le_max, clk_i, rst_ni, in_elem_q, min_q <= max_q)
  `ERQ_ASSERT_NOW(a_deg_zero, clk_i, rst_ni, out_valid_o && out_item_o.degenerate, out_item_o.quality == '0)
  `ERQ_ASSERT_NEXT(a_emit_loads, clk_i, rst_ni, ctrl.state == ST_EMIT && out_free, out_valid_o && ctrl.state == ST_IDLE)

endmodule

`default_nettype wire
